// ===== design/hmsw_pkg.sv =====
// Shared types, request codes and limits for the hours:minutes:seconds stopwatch.
`timescale 1ns / 1ps

package hmsw_pkg;

  // Request codes carried in req_type
  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_RESET  = 3'd1;
  localparam logic [2:0] REQ_PAUSE  = 3'd2;
  localparam logic [2:0] REQ_RESUME = 3'd3;
  localparam logic [2:0] REQ_BUTTON = 3'd4;
  // Spare codes, no effect on the state
  localparam logic [2:0] REQ_SPARE5 = 3'd5;
  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;

  // Button bit positions
  localparam int unsigned BTN_SEC_UP   = 0;
  localparam int unsigned BTN_SEC_DN   = 1;
  localparam int unsigned BTN_MIN_UP   = 2;
  localparam int unsigned BTN_MIN_DN   = 3;
  localparam int unsigned BTN_HOUR_UP  = 4;
  localparam int unsigned BTN_HOUR_DN  = 5;

  // Counter limits
  localparam logic [5:0] SEC_MAX  = 6'd59;
  localparam logic [5:0] MIN_MAX  = 6'd59;
  localparam logic [4:0] HOUR_MAX = 5'd23;

  typedef struct packed {
    logic [2:0] req_type;
    logic       count_down_sel;
    logic [5:0] buttons;
  } in_beat_t;

  typedef struct packed {
    logic [3:0] sec_unit;
    logic [2:0] sec_ten;
    logic [3:0] min_unit;
    logic [2:0] min_ten;
    logic [3:0] hour_unit;
    logic [1:0] hour_ten;
    logic       running;
    logic       counting_down;
    logic       done_res;
  } out_beat_t;

  // Time and status after one event, as handed from the core to the output stage
  typedef struct packed {
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
    logic       running;
    logic       done;
  } hms_state_t;

endpackage

// ===== design/hms_up_down_stopwatch_top.sv =====
// Top level of the hours:minutes:seconds up/down stopwatch.
//
//  channel  | direction | handshake              | beat
//  ---------+-----------+------------------------+-----------
//  events   | in        | in_valid_i / in_stall_o   | in_beat_t
//  results  | out       | out_valid_o / out_stall_i | out_beat_t
//
// One event per clock sustained unless stalled; each event gives one result
// via the input register, then the result register. The update is a single
// pass of carry/borrow logic on the time counters between the two registers.
// Reset returns to 00:00:00, running, not in adjust mode, done clear.
// A stalled result holds the pipe; the input register still takes an event
// and raises in_stall_o only while it holds one that cannot move on.
`timescale 1ns / 1ps

module hms_up_down_stopwatch_top
  import hmsw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  logic       in_valid_q;
  in_beat_t   in_beat_q;
  logic       out_valid_q;
  out_beat_t  out_beat_q, out_beat_d;
  logic       advance;
  logic       in_take;
  hms_state_t next_state;

  // Event moves on when the result register is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_beat_q <= in_beat_i;
    end
  end

  hmsw_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .beat_i    (in_beat_q),
    .next_o    (next_state)
  );

  logic [2:0] hour_ten_w;

  hmsw_bcd u_bcd_sec (
    .value_i (next_state.seconds),
    .tens_o  (out_beat_d.sec_ten),
    .ones_o  (out_beat_d.sec_unit)
  );

  hmsw_bcd u_bcd_min (
    .value_i (next_state.minutes),
    .tens_o  (out_beat_d.min_ten),
    .ones_o  (out_beat_d.min_unit)
  );

  hmsw_bcd u_bcd_hour (
    .value_i ({1'b0, next_state.hours}),
    .tens_o  (hour_ten_w),
    .ones_o  (out_beat_d.hour_unit)
  );

  assign out_beat_d.hour_ten      = hour_ten_w[1:0];
  assign out_beat_d.running       = next_state.running;
  assign out_beat_d.counting_down = in_beat_q.count_down_sel;
  assign out_beat_d.done_res      = next_state.done;

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_beat_q <= out_beat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

// ===== design/hmsw_bcd.sv =====
// Binary to two-digit BCD split for values up to 63.
`timescale 1ns / 1ps

module hmsw_bcd (
  input  logic [5:0] value_i,
  output logic [2:0] tens_o,
  output logic [3:0] ones_o
);

  logic [6:0] tens_x10;

  // Tens by compare chain, units by subtracting tens times ten
  always_comb begin
    if (value_i >= 6'd60) begin
      tens_o = 3'd6;
    end else if (value_i >= 6'd50) begin
      tens_o = 3'd5;
    end else if (value_i >= 6'd40) begin
      tens_o = 3'd4;
    end else if (value_i >= 6'd30) begin
      tens_o = 3'd3;
    end else if (value_i >= 6'd20) begin
      tens_o = 3'd2;
    end else if (value_i >= 6'd10) begin
      tens_o = 3'd1;
    end else begin
      tens_o = 3'd0;
    end
    tens_x10 = {1'b0, tens_o, 3'b000} + {3'b000, tens_o, 1'b0};
    ones_o   = 4'(7'({1'b0, value_i}) - tens_x10);
  end

endmodule

// ===== design/hmsw_core.sv =====
// Time and mode registers with the per-event update logic.
`timescale 1ns / 1ps

module hmsw_core
  import hmsw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  in_beat_t   beat_i,
  output hms_state_t next_o
);

  logic [5:0] sec_q, sec_d;
  logic [5:0] min_q, min_d;
  logic [4:0] hour_q, hour_d;
  logic       run_q, run_d;
  logic       adj_q, adj_d;
  logic       latch_q, latch_d;
  logic       fin_q, fin_d;

  logic       all_zero;
  logic       down_zero;

  assign all_zero = (sec_q == '0) && (min_q == '0) && (hour_q == '0);
  // Count after a down tick is zero: only 0:00:01 gets there
  assign down_zero = (hour_q == '0) && (min_q == '0) && (sec_q == 6'd1);

  // Next state for the event in the input register
  always_comb begin
    sec_d   = sec_q;
    min_d   = min_q;
    hour_d  = hour_q;
    run_d   = run_q;
    adj_d   = adj_q;
    latch_d = latch_q;
    fin_d   = fin_q;
    unique case (beat_i.req_type)
      REQ_TICK: begin
        if (run_q && beat_i.count_down_sel) begin
          if (all_zero || down_zero) begin
            fin_d = 1'b1;
            run_d = 1'b0;
          end
          if (!all_zero) begin
            if (sec_q != '0) begin
              sec_d = sec_q - 6'd1;
            end else begin
              sec_d = SEC_MAX;
              if (min_q != '0) begin
                min_d = min_q - 6'd1;
              end else begin
                min_d  = MIN_MAX;
                hour_d = hour_q - 5'd1;
              end
            end
          end
        end else if (run_q) begin
          if (sec_q >= SEC_MAX) begin
            sec_d = '0;
            if (min_q >= MIN_MAX) begin
              min_d  = '0;
              hour_d = (hour_q >= HOUR_MAX) ? '0 : hour_q + 5'd1;
            end else begin
              min_d = min_q + 6'd1;
            end
          end else begin
            sec_d = sec_q + 6'd1;
          end
        end
      end
      REQ_RESET: begin
        sec_d   = '0;
        min_d   = '0;
        hour_d  = '0;
        run_d   = 1'b1;
        adj_d   = 1'b0;
        latch_d = 1'b0;
        fin_d   = 1'b0;
      end
      REQ_PAUSE: begin
        run_d = 1'b0;
        adj_d = 1'b1;
      end
      REQ_RESUME: begin
        run_d = 1'b1;
        adj_d = 1'b0;
        fin_d = 1'b0;
      end
      REQ_BUTTON: begin
        if (adj_q) begin
          if (beat_i.buttons == '0) begin
            latch_d = 1'b0;
          end else if (!latch_q) begin
            // One step per hold, lowest pressed button wins
            latch_d = 1'b1;
            if (beat_i.buttons[BTN_SEC_UP]) begin
              sec_d = (sec_q >= SEC_MAX) ? '0 : sec_q + 6'd1;
            end else if (beat_i.buttons[BTN_SEC_DN]) begin
              sec_d = (sec_q == '0) ? SEC_MAX : sec_q - 6'd1;
            end else if (beat_i.buttons[BTN_MIN_UP]) begin
              min_d = (min_q >= MIN_MAX) ? '0 : min_q + 6'd1;
            end else if (beat_i.buttons[BTN_MIN_DN]) begin
              min_d = (min_q == '0) ? MIN_MAX : min_q - 6'd1;
            end else if (beat_i.buttons[BTN_HOUR_UP]) begin
              hour_d = (hour_q >= HOUR_MAX) ? '0 : hour_q + 5'd1;
            end else if (beat_i.buttons[BTN_HOUR_DN] && (hour_q != '0)) begin
              hour_d = hour_q - 5'd1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // State registers, updated once per event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q   <= '0;
      min_q   <= '0;
      hour_q  <= '0;
      run_q   <= 1'b1;
      adj_q   <= 1'b0;
      latch_q <= 1'b0;
      fin_q   <= 1'b0;
    end else if (advance_i) begin
      sec_q   <= sec_d;
      min_q   <= min_d;
      hour_q  <= hour_d;
      run_q   <= run_d;
      adj_q   <= adj_d;
      latch_q <= latch_d;
      fin_q   <= fin_d;
    end
  end

  assign next_o.seconds = sec_d;
  assign next_o.minutes = min_d;
  assign next_o.hours   = hour_d;
  assign next_o.running = run_d;
  assign next_o.done    = fin_d;

  // Counters stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sec_q <= SEC_MAX) && (min_q <= MIN_MAX) && (hour_q <= HOUR_MAX))
    else $error("time counter out of range");

  // A finished countdown is never running
  assert property (@(posedge clk_i) disable iff (!rst_ni) fin_q |-> !run_q)
    else $error("done set while running");

  // Adjust mode only while stopped
  assert property (@(posedge clk_i) disable iff (!rst_ni) adj_q |-> !run_q)
    else $error("adjust mode while running");

  // No event, no change of time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> ($stable(sec_q) && $stable(min_q) && $stable(hour_q)))
    else $error("time changed without an event");

endmodule
